/* hdl/abhfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abhfr_pkg: shared types and constants of the ASCII-hex frame receiver
// Character codes, frame limits, register indexes and the frame-end record
// that travels from the front end to the result stage.
// ----------------------------------------------------------------------------
package abhfr_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam int GAP_W  = 16;
    localparam int ADDR_W = 8;
    localparam int CFG_W  = 16;

    localparam logic       FUNC_BYTE = 1'b0;
    localparam logic       FUNC_TICK = 1'b1;
    localparam logic       END_CR    = 1'b0;
    localparam logic       END_IDLE  = 1'b1;

    localparam logic       REG_GAP   = 1'b0;
    localparam logic       REG_ADDR  = 1'b1;

    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam int         MIN_FRAME  = 18;
    localparam logic [7:0] GROUP_CODE = 8'h46;
    localparam logic [7:0] RET_NORMAL = 8'h00;
    localparam logic [7:0] RET_ALT_A  = 8'h90;
    localparam logic [7:0] RET_ALT_B  = 8'h91;

    localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd5000;
    localparam logic [ADDR_W-1:0] ADDR_RESET = 8'd2;
    localparam logic [GAP_W-1:0]  IDLE_MAX   = 16'hFFFF;

    // One finished frame, as seen by the front end
    typedef struct packed {
        logic             kind;
        logic             wf;
        logic [CNT_W-1:0] count;
        logic [31:0]      hdr;
    } frame_ev_t;

endpackage : abhfr_pkg
`default_nettype wire

/* hdl/abhfr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abhfr_front: frame assembly front end
// Tracks the open frame one word at a time, classifies each byte, watches
// the idle gap and posts a record for each frame closed by CR or idle gap.
// ----------------------------------------------------------------------------
module abhfr_front
    import abhfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_accept,
    input  wire logic             func,
    input  wire logic [7:0]       data_byte,
    input  wire logic [GAP_W-1:0] gap_ticks,
    output logic                  ev_valid,
    output frame_ev_t             ev
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             tilde_reg, tilde_next;
    logic             allhex_reg, allhex_next;
    logic [31:0]      hdr_reg, hdr_next;
    logic [GAP_W-1:0] idle_reg, idle_next;

    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    always_comb
    begin
        logic             open_frame;
        logic [GAP_W-1:0] idle_inc;
        logic             drop;
        logic [CNT_W-1:0] pos;
        logic             tilde_b;
        logic             allhex_b;
        logic [31:0]      hdr_b;
        logic [4:0]       hx;
        logic [CNT_W-1:0] len;

        count_next  = count_reg;
        tilde_next  = tilde_reg;
        allhex_next = allhex_reg;
        hdr_next    = hdr_reg;
        idle_next   = idle_reg;
        ev_valid    = 1'b0;
        ev          = '0;

        open_frame = (count_reg != '0);
        idle_inc   = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + GAP_W'(1);
        drop       = (open_frame && (idle_reg > gap_ticks)) ||
                     (count_reg >= CNT_W'(BUF_DEPTH));
        pos        = drop ? '0 : count_reg;
        tilde_b    = drop ? 1'b0 : tilde_reg;
        allhex_b   = drop ? 1'b1 : allhex_reg;
        hdr_b      = drop ? 32'd0 : hdr_reg;
        hx         = hex_nib(data_byte);
        len        = pos + CNT_W'(1);

        if (pos == '0)
            tilde_b = (data_byte == CHAR_TILDE);
        else if (data_byte != CHAR_CR)
        begin
            if (!hx[4])
                allhex_b = 1'b0;
            for (int i = 1; i <= 8; i++)
            begin
                if (pos == CNT_W'(i) && hx[4])
                    hdr_b[(8 - i) * 4 +: 4] = hdr_b[(8 - i) * 4 +: 4] | hx[3:0];
            end
        end

        if (in_accept)
        begin
            if (func == FUNC_TICK)
            begin
                if (open_frame)
                begin
                    if (idle_inc > gap_ticks)
                    begin
                        // idle gap exceeded: report the partial frame and close it
                        ev_valid    = 1'b1;
                        ev.kind     = END_IDLE;
                        ev.wf       = 1'b0;
                        ev.count    = count_reg;
                        ev.hdr      = 32'd0;
                        count_next  = '0;
                        tilde_next  = 1'b0;
                        allhex_next = 1'b1;
                        hdr_next    = 32'd0;
                        idle_next   = '0;
                    end
                    else
                        idle_next = idle_inc;
                end
            end
            else if (data_byte == CHAR_CR)
            begin
                ev_valid    = 1'b1;
                ev.kind     = END_CR;
                ev.wf       = (len >= CNT_W'(MIN_FRAME)) && tilde_b && allhex_b;
                ev.count    = len;
                ev.hdr      = hdr_b;
                count_next  = '0;
                tilde_next  = 1'b0;
                allhex_next = 1'b1;
                hdr_next    = 32'd0;
                idle_next   = '0;
            end
            else
            begin
                count_next  = len;
                tilde_next  = tilde_b;
                allhex_next = allhex_b;
                hdr_next    = hdr_b;
                idle_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            tilde_reg  <= 1'b0;
            allhex_reg <= 1'b1;
            hdr_reg    <= 32'd0;
            idle_reg   <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            tilde_reg  <= tilde_next;
            allhex_reg <= allhex_next;
            hdr_reg    <= hdr_next;
            idle_reg   <= idle_next;
        end
    end

    a_byte_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func == FUNC_BYTE) |=> (idle_reg == '0))
        else $error("idle count not cleared by a received byte");

    a_cr_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func == FUNC_BYTE && data_byte == CHAR_CR) |=> (count_reg == '0))
        else $error("frame still open after carriage return");

endmodule : abhfr_front
`default_nettype wire

/* hdl/abhfr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abhfr_queue: frame-end record queue
// Short first-in first-out store between the front end and the result stage.
// ----------------------------------------------------------------------------
module abhfr_queue
    import abhfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire frame_ev_t wr_item,
    input  wire logic      rd_en,
    output frame_ev_t      rd_item,
    output logic           full,
    output logic           empty
);

    frame_ev_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("record posted to a full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) == Q_PTR_W'(cnt_reg))
        else $error("queue pointers disagree with fill count");

endmodule : abhfr_queue
`default_nettype wire

/* hdl/abhfr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abhfr_back: result stage
// Decodes one frame-end record into header bytes, info length, length word
// and reply check, and holds it in the output register until popped.
// ----------------------------------------------------------------------------
module abhfr_back
    import abhfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire frame_ev_t         q_item,
    output logic                   q_pop,
    input  wire logic [ADDR_W-1:0] expected_address,
    input  wire logic              pop,
    output logic                   empty,
    output logic                   end_kind,
    output logic                   well_formed,
    output logic [8:0]             frame_length,
    output logic [7:0]             version_byte,
    output logic [7:0]             device_address,
    output logic [7:0]             command_group,
    output logic [7:0]             command_or_return,
    output logic [7:0]             info_length,
    output logic [15:0]            length_word,
    output logic                   reply_ok
);

    logic        valid_reg, valid_next;
    logic        kind_reg, wf_reg, ok_reg;
    logic [8:0]  len_reg;
    logic [7:0]  ver_reg, adr_reg, grp_reg, code_reg, info_reg;
    logic [15:0] lw_reg;

    logic [15:0] cnt16, info16;
    logic [11:0] id12;
    logic [3:0]  nsum;
    logic [7:0]  ver_c, adr_c, grp_c, code_c, info_c;
    logic [15:0] lw_c;
    logic        ok_c;

    assign q_pop = !q_empty && (!valid_reg || pop);

    always_comb
    begin
        cnt16  = 16'(q_item.count);
        info16 = cnt16 - 16'(MIN_FRAME);
        id12   = info16[11:0];
        nsum   = id12[11:8] + id12[7:4] + id12[3:0];
        ver_c  = 8'd0;
        adr_c  = 8'd0;
        grp_c  = 8'd0;
        code_c = 8'd0;
        info_c = 8'd0;
        lw_c   = 16'd0;
        ok_c   = 1'b0;
        // malformed and partial frames report zeros past the length
        if (q_item.wf)
        begin
            ver_c  = q_item.hdr[31:24];
            adr_c  = q_item.hdr[23:16];
            grp_c  = q_item.hdr[15:8];
            code_c = q_item.hdr[7:0];
            info_c = info16[7:0];
            lw_c   = {4'(4'd0 - nsum), id12};
            ok_c   = (grp_c == GROUP_CODE) && (adr_c == expected_address) &&
                     ((code_c == RET_NORMAL) || (code_c == RET_ALT_A) ||
                      (code_c == RET_ALT_B));
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= q_item.kind;
            wf_reg   <= q_item.wf;
            len_reg  <= cnt16[8:0];
            ver_reg  <= ver_c;
            adr_reg  <= adr_c;
            grp_reg  <= grp_c;
            code_reg <= code_c;
            info_reg <= info_c;
            lw_reg   <= lw_c;
            ok_reg   <= ok_c;
        end
    end

    assign empty             = !valid_reg;
    assign end_kind          = kind_reg;
    assign well_formed       = wf_reg;
    assign frame_length      = len_reg;
    assign version_byte      = ver_reg;
    assign device_address    = adr_reg;
    assign command_group     = grp_reg;
    assign command_or_return = code_reg;
    assign info_length       = info_reg;
    assign length_word       = lw_reg;
    assign reply_ok          = ok_reg;

    a_ok_needs_wf: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ok_reg) |-> wf_reg)
        else $error("reply accepted on a malformed frame");

    a_partial_malformed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == END_IDLE) |-> (!wf_reg && lw_reg == 16'd0))
        else $error("partial frame reported as well formed");

endmodule : abhfr_back
`default_nettype wire

/* hdl/ascii_hex_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_hex_frame_receiver: serial ASCII-hex frame receiver top level
// Holds the configuration registers and joins front end, record queue and
// result stage.
//
// Channel   Direction  Handshake          Word
// input     in         push / full        func, data_byte
// result    out        empty / pop        end_kind .. reply_ok (10 fields)
// config    in         cfg_we             cfg_index, cfg_data
//
// One input word per cycle while full is low. A result reaches the ports
// through the record queue: the front end posts a record at the accept
// edge, the result stage loads it once its register is empty or popped.
// full rises only when the four-entry record queue is full, which takes the
// result register to be held by a low pop.
// Reset clears the frame state, the queue and the result register and loads
// gap_ticks 5000 and expected_address 2.
// ----------------------------------------------------------------------------
module ascii_hex_frame_receiver
    import abhfr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic             func,
    input  wire logic [7:0]       data_byte,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  end_kind,
    output logic                  well_formed,
    output logic [8:0]            frame_length,
    output logic [7:0]            version_byte,
    output logic [7:0]            device_address,
    output logic [7:0]            command_group,
    output logic [7:0]            command_or_return,
    output logic [7:0]            info_length,
    output logic [15:0]           length_word,
    output logic                  reply_ok,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [GAP_W-1:0]  gap_reg, gap_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              in_accept;
    logic              ev_valid;
    frame_ev_t         ev;
    logic              q_full, q_empty, q_pop;
    frame_ev_t         q_item;

    assign full      = q_full;
    assign in_accept = push && !q_full;

    always_comb
    begin
        gap_next  = gap_reg;
        addr_next = addr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAP:  gap_next  = cfg_data[GAP_W-1:0];
                REG_ADDR: addr_next = cfg_data[ADDR_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg  <= GAP_RESET;
            addr_reg <= ADDR_RESET;
        end
        else
        begin
            gap_reg  <= gap_next;
            addr_reg <= addr_next;
        end
    end

    abhfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .func      (func),
        .data_byte (data_byte),
        .gap_ticks (gap_reg),
        .ev_valid  (ev_valid),
        .ev        (ev)
    );

    abhfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ev_valid),
        .wr_item (ev),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    abhfr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .expected_address  (addr_reg),
        .pop               (pop),
        .empty             (empty),
        .end_kind          (end_kind),
        .well_formed       (well_formed),
        .frame_length      (frame_length),
        .version_byte      (version_byte),
        .device_address    (device_address),
        .command_group     (command_group),
        .command_or_return (command_or_return),
        .info_length       (info_length),
        .length_word       (length_word),
        .reply_ok          (reply_ok)
    );

endmodule : ascii_hex_frame_receiver
`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ASCII-hex frame receiver
// Feeds bytes and time ticks through the push/full side, predicts every frame
// report in a behavioral tracker and checks each popped word field by field.
// Covers reply frames, malformed and short frames, idle-gap partials, buffer
// overflow and a lowered gap limit.
// ----------------------------------------------------------------------------
module tb_top;
    import abhfr_pkg::*;

    localparam int  MAX_SHOWN     = 10;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  NUM_PHASES    = 8;
    localparam int  PHASE_WORDS   = 150;
    localparam real TIME_LIMIT_NS = 10.0e6;

    // frame shapes for the stimulus builder
    localparam int SHAPE_CLEAN    = 0;
    localparam int SHAPE_BAD_CHAR = 1;
    localparam int SHAPE_NO_TILDE = 2;
    localparam int SHAPE_SHORT    = 3;
    localparam int SHAPE_PARTIAL  = 4;

    typedef struct packed {
        logic       func;
        logic [7:0] data;
    } rx_word_t;

    typedef struct packed {
        logic        kind;
        logic        wf;
        logic [8:0]  len;
        logic [7:0]  ver;
        logic [7:0]  adr;
        logic [7:0]  grp;
        logic [7:0]  code;
        logic [7:0]  info;
        logic [15:0] lword;
        logic        ok;
    } frame_report_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic             func = 1'b0;
    logic [7:0]       data_byte = 8'h00;
    logic             empty;
    logic             pop = 1'b0;
    logic             end_kind;
    logic             well_formed;
    logic [8:0]       frame_length;
    logic [7:0]       version_byte;
    logic [7:0]       device_address;
    logic [7:0]       command_group;
    logic [7:0]       command_or_return;
    logic [7:0]       info_length;
    logic [15:0]      length_word;
    logic             reply_ok;
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    ascii_hex_frame_receiver i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .func              (func),
        .data_byte         (data_byte),
        .empty             (empty),
        .pop               (pop),
        .end_kind          (end_kind),
        .well_formed       (well_formed),
        .frame_length      (frame_length),
        .version_byte      (version_byte),
        .device_address    (device_address),
        .command_group     (command_group),
        .command_or_return (command_or_return),
        .info_length       (info_length),
        .length_word       (length_word),
        .reply_ok          (reply_ok),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // tracker copy of configuration and frame state
    logic [15:0]   cfg_gap   = GAP_RESET;
    logic [7:0]    cfg_addr  = ADDR_RESET;
    int            fr_count  = 0;
    bit            fr_open   = 1'b0;
    bit            fr_tilde  = 1'b0;
    bit            fr_allhex = 1'b1;
    logic [31:0]   fr_hdr    = '0;
    int            fr_idle   = 0;

    rx_word_t      rx_words_q[$];
    frame_report_t frame_reports_q[$];

    int words_in_flight = 0;
    int words_queued    = 0;
    int words_accepted  = 0;
    int error_count     = 0;
    int reports_cr      = 0;
    int reports_idle    = 0;
    int reports_wf      = 0;
    int reports_ok      = 0;
    int long_frames     = 0;
    int overflow_runs   = 0;

    rx_word_t drv_word;
    int       drv_gap    = 0;
    int       drv_run    = 0;
    int       mon_stall  = 0;
    int       mon_run    = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #(TIME_LIMIT_NS);
        $display("timeout: %0d words still queued, %0d reports outstanding",
                 words_in_flight, frame_reports_q.size());
        $display("[ascii_hex_frame_receiver] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame tracker
    // ------------------------------------------------------------------
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    // top nibble makes the four length-word nibbles sum to zero mod 16
    function automatic logic [15:0] length_word_of(input logic [11:0] info);
        logic [3:0] sum;
        sum = info[11:8] + info[7:4] + info[3:0];
        return {4'd0 - sum, info};
    endfunction

    task automatic clear_frame();
        fr_count  = 0;
        fr_open   = 1'b0;
        fr_tilde  = 1'b0;
        fr_allhex = 1'b1;
        fr_hdr    = '0;
        fr_idle   = 0;
    endtask

    task automatic post_report(input logic kind, input logic wf);
        frame_report_t r;
        r       = '0;
        r.kind  = kind;
        r.wf    = wf;
        r.len   = 9'(fr_count);
        if (wf) begin
            r.ver   = fr_hdr[31:24];
            r.adr   = fr_hdr[23:16];
            r.grp   = fr_hdr[15:8];
            r.code  = fr_hdr[7:0];
            r.info  = 8'(fr_count - MIN_FRAME);
            r.lword = length_word_of(12'(fr_count - MIN_FRAME));
            r.ok    = (r.grp == GROUP_CODE) && (r.adr == cfg_addr) &&
                      (r.code == RET_NORMAL || r.code == RET_ALT_A || r.code == RET_ALT_B);
        end
        frame_reports_q.push_back(r);
    endtask

    task automatic track_rx_word(input logic f, input logic [7:0] d);
        int nib;
        if (f == FUNC_TICK) begin
            if (fr_open) begin
                if (fr_idle < 65535) fr_idle++;
                if (fr_idle > cfg_gap) begin
                    post_report(END_IDLE, 1'b0);
                    clear_frame();
                end
            end
        end
        else begin
            // a gap limit lowered under an open frame drops it silently
            if (fr_open && fr_idle > cfg_gap) clear_frame();
            if (fr_count >= BUF_DEPTH) clear_frame();
            if (fr_count == 0) begin
                fr_tilde = (d == CHAR_TILDE);
            end
            else if (d != CHAR_CR) begin
                nib = nibble_of(d);
                if (nib < 0) fr_allhex = 1'b0;
                else if (fr_count <= 8) fr_hdr[(8 - fr_count) * 4 +: 4] = nib[3:0];
            end
            fr_count++;
            fr_open = 1'b1;
            fr_idle = 0;
            if (d == CHAR_CR) begin
                post_report(END_CR, fr_count >= MIN_FRAME && fr_tilde && fr_allhex);
                clear_frame();
            end
        end
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: one word per push, held while full
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            if (push && !full) begin
                track_rx_word(func, data_byte);
                words_in_flight--;
                words_accepted++;
            end
            if (!(push && full)) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    push <= 1'b0;
                end
                else if (rx_words_q.size() != 0) begin
                    drv_word  = rx_words_q.pop_front();
                    push      <= 1'b1;
                    func      <= drv_word.func;
                    data_byte <= drv_word.data;
                    drv_gap   = (drv_run > 0) ? 0 : random_gap();
                    if (drv_run > 0) drv_run--;
                    else if ($urandom_range(0, 49) == 0) drv_run = $urandom_range(20, 80);
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pop with random stalls, check against the oldest report
    // ------------------------------------------------------------------
    function automatic string fmt_report(input frame_report_t r);
        return {$sformatf("kind=%0d wf=%0d len=%0d ver=%02h adr=%02h grp=%02h ",
                          r.kind, r.wf, r.len, r.ver, r.adr, r.grp),
                $sformatf("code=%02h info=%0d lw=%04h ok=%0d",
                          r.code, r.info, r.lword, r.ok)};
    endfunction

    task automatic check_report();
        frame_report_t seen;
        frame_report_t want;
        seen.kind  = end_kind;
        seen.wf    = well_formed;
        seen.len   = frame_length;
        seen.ver   = version_byte;
        seen.adr   = device_address;
        seen.grp   = command_group;
        seen.code  = command_or_return;
        seen.info  = info_length;
        seen.lword = length_word;
        seen.ok    = reply_ok;
        if (frame_reports_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
                $display("%0t: unexpected report %s", $realtime, fmt_report(seen));
        end
        else begin
            want = frame_reports_q.pop_front();
            if (want.kind == END_CR) reports_cr++;
            else reports_idle++;
            if (want.wf) reports_wf++;
            if (want.ok) reports_ok++;
            if (seen !== want) begin
                error_count++;
                if (error_count <= MAX_SHOWN) begin
                    $display("%0t: report mismatch", $realtime);
                    $display("    expected %s", fmt_report(want));
                    $display("    actual   %s", fmt_report(seen));
                end
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else begin
            if (pop && !empty) begin
                check_report();
                mon_stall = (mon_run > 0) ? 0 : random_gap();
                if (mon_run > 0) mon_run--;
                else if ($urandom_range(0, 29) == 0) mon_run = $urandom_range(10, 40);
            end
            if (mon_stall > 0) begin
                mon_stall--;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic put_word(input logic f, input logic [7:0] d);
        rx_word_t w;
        w.func = f;
        w.data = d;
        rx_words_q.push_back(w);
        words_in_flight++;
        words_queued++;
    endtask

    // data_byte carries noise on ticks
    task automatic put_ticks(input int n);
        for (int i = 0; i < n; i++) put_word(FUNC_TICK, 8'($urandom));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] letter_a;
        letter_a = ($urandom_range(0, 3) == 0) ? 8'h61 : 8'h41;
        if (v < 10) return 8'h30 + v;
        return 8'(letter_a + v - 10);
    endfunction

    // ticks between bytes never exceed the gap limit
    function automatic int safe_ticks();
        if ($urandom_range(0, 4) != 0) return 0;
        return $urandom_range(1, (cfg_gap < 3) ? int'(cfg_gap) : 3);
    endfunction

    task automatic put_frame(input logic [7:0] ver, input logic [7:0] adr,
                             input logic [7:0] grp, input logic [7:0] code,
                             input int info_len, input int shape);
        logic [7:0]  chars[$];
        logic [31:0] hdr;
        logic [15:0] lw;
        int          cut;
        int          pos;
        hdr = {ver, adr, grp, code};
        lw  = length_word_of(12'(info_len));
        chars.push_back(CHAR_TILDE);
        for (int i = 7; i >= 0; i--) chars.push_back(hex_char(hdr[i * 4 +: 4]));
        for (int i = 3; i >= 0; i--) chars.push_back(hex_char(lw[i * 4 +: 4]));
        for (int i = 0; i < info_len; i++) chars.push_back(hex_char(4'($urandom)));
        for (int i = 0; i < 4; i++) chars.push_back(hex_char(4'($urandom)));
        chars.push_back(CHAR_CR);
        case (shape)
            SHAPE_BAD_CHAR: begin
                pos = $urandom_range(1, chars.size() - 2);
                chars[pos] = 8'($urandom);
            end
            SHAPE_NO_TILDE: begin
                chars[0] = 8'($urandom);
                if (chars[0] == CHAR_TILDE) chars[0] = 8'h40;
            end
            SHAPE_SHORT: begin
                cut = $urandom_range(1, MIN_FRAME - 2);
                while (chars.size() > cut) void'(chars.pop_back());
                chars.push_back(CHAR_CR);
            end
            SHAPE_PARTIAL: begin
                cut = $urandom_range(1, chars.size() - 1);
                while (chars.size() > cut) void'(chars.pop_back());
            end
            default: ;
        endcase
        foreach (chars[i]) begin
            if (i > 0) put_ticks(safe_ticks());
            put_word(FUNC_BYTE, chars[i]);
        end
        if (shape == SHAPE_PARTIAL) put_ticks(int'(cfg_gap) + 1 + $urandom_range(0, 2));
    endtask

    task automatic put_random_frame();
        logic [7:0] ver;
        logic [7:0] adr;
        logic [7:0] grp;
        logic [7:0] code;
        int         info_len;
        int         shape;
        int         r;
        ver = ($urandom_range(0, 3) != 0) ? 8'h20 : 8'($urandom);
        adr = ($urandom_range(0, 1) != 0) ? cfg_addr : 8'($urandom);
        grp = ($urandom_range(0, 9) < 7) ? GROUP_CODE : 8'($urandom);
        case ($urandom_range(0, 3))
            0:       code = RET_NORMAL;
            1:       code = RET_ALT_A;
            2:       code = RET_ALT_B;
            default: code = 8'($urandom);
        endcase
        r = $urandom_range(0, 99);
        if (r < 80) begin
            info_len = $urandom_range(0, 12);
        end
        else if (r < 97 || long_frames >= 4) begin
            info_len = $urandom_range(13, 60);
        end
        else begin
            long_frames++;
            info_len = $urandom_range(200, BUF_DEPTH - MIN_FRAME);
        end
        r = $urandom_range(0, 99);
        if (r < 75)      shape = SHAPE_CLEAN;
        else if (r < 85) shape = SHAPE_BAD_CHAR;
        else if (r < 90) shape = SHAPE_NO_TILDE;
        else if (r < 95) shape = SHAPE_SHORT;
        else             shape = (cfg_gap <= 64) ? SHAPE_PARTIAL : SHAPE_CLEAN;
        put_frame(ver, adr, grp, code, info_len, shape);
    endtask

    task automatic wait_idle();
        while (words_in_flight != 0 || frame_reports_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_GAP) cfg_gap = value;
        else cfg_addr = value[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int          r;
        int          n;
        int          phase_end;
        logic [15:0] gap;
        logic [7:0]  addr;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setup, lone CR, minimum reply, partial, lowered limit
        put_ticks(2);
        put_word(FUNC_BYTE, CHAR_CR);
        put_frame(8'h20, ADDR_RESET, GROUP_CODE, RET_NORMAL, 0, SHAPE_CLEAN);
        write_reg(REG_GAP, 16'd1);
        write_reg(REG_ADDR, {8'h5A, 8'h00});
        put_frame(8'h20, 8'h00, GROUP_CODE, RET_ALT_B, 1, SHAPE_CLEAN);
        put_word(FUNC_BYTE, CHAR_TILDE);
        put_word(FUNC_BYTE, 8'h35);
        put_ticks(2);
        write_reg(REG_GAP, 16'd10);
        put_word(FUNC_BYTE, CHAR_TILDE);
        put_ticks(4);
        // idle count now above the new limit: next byte opens a fresh frame
        write_reg(REG_GAP, 16'd2);
        put_word(FUNC_BYTE, CHAR_CR);

        for (int p = 0; p < NUM_PHASES; p++) begin
            r = $urandom_range(0, 99);
            if (r < 20)      gap = 16'd1;
            else if (r < 70) gap = 16'($urandom_range(2, 20));
            else if (r < 90) gap = 16'($urandom_range(21, 64));
            else             gap = 16'($urandom_range(65, 5000));
            if (p == 0)      addr = 8'hFF;
            else if (p == 1) addr = 8'h00;
            else             addr = ($urandom_range(0, 3) == 0) ? cfg_addr : 8'($urandom);
            write_reg(REG_GAP, gap);
            write_reg(REG_ADDR, {8'($urandom), addr});

            phase_end = words_queued + PHASE_WORDS;
            while (words_queued < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    put_random_frame();
                end
                else if (r < 80) begin
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++) put_word(FUNC_BYTE, 8'($urandom));
                    if ($urandom_range(0, 1) != 0) put_word(FUNC_BYTE, CHAR_CR);
                end
                else if (r < 86) begin
                    put_word(FUNC_BYTE, CHAR_CR);
                end
                else if (r < 97 || overflow_runs >= 2) begin
                    put_ticks($urandom_range(1, (cfg_gap <= 64) ? int'(cfg_gap) + 2 : 6));
                end
                else begin
                    // fill the buffer; the next frame's first byte drops it silently
                    overflow_runs++;
                    put_word(FUNC_BYTE, CHAR_TILDE);
                    for (int i = 1; i < BUF_DEPTH; i++) put_word(FUNC_BYTE, hex_char(4'($urandom)));
                    put_random_frame();
                end
            end
        end

        wait_idle();

        $display("%0d words accepted; %0d reports (%0d at CR, %0d on idle gap)",
                 words_accepted, reports_cr + reports_idle, reports_cr, reports_idle);
        $display("%0d well formed, %0d good replies, %0d long frames, %0d overflows, %0d errors",
                 reports_wf, reports_ok, long_frames, overflow_runs, error_count);
        if (error_count == 0) begin
            $display("[ascii_hex_frame_receiver] OK");
        end
        else begin
            $display("[ascii_hex_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/abhfr_pkg.sv
hdl/abhfr_front.sv
hdl/abhfr_queue.sv
hdl/abhfr_back.sv
hdl/ascii_hex_frame_receiver.sv
verif/tb_top.sv
